// ===== hw/rtl/kmhll_pkg.sv =====
`default_nettype none

package kmhll_pkg;

    // sketch geometry
    localparam int PRECISION    = 12;
    localparam int IDX_W        = PRECISION;
    localparam int KMER_LENGTH  = 32;
    localparam int WIN_W        = 2 * KMER_LENGTH;
    localparam int HELD_W       = $clog2(KMER_LENGTH + 1);

    // word field widths
    localparam int CHAR_W       = 8;
    localparam int REG_IDX_W    = 12;
    localparam int RANK_W       = 6;
    localparam int RSUM_W       = RANK_W + 1;

    // fmix64 finalizer
    localparam int          HASH_W    = 64;
    localparam int          HALF_W    = HASH_W / 2;
    localparam int          MIX_SHIFT = 33;
    localparam logic [63:0] FMIX_C0   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C1   = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] HASH_SEED = 64'd42;

    // rank search: tail split into chunks, each priority-encoded on its own
    localparam int LZ_CHUNK  = 16;
    localparam int LZ_CHUNKS = HASH_W / LZ_CHUNK;
    localparam int LZ_W      = $clog2(LZ_CHUNK + 1);
    localparam int MAX_RANK  = HASH_W - PRECISION + 1;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       bad;
        logic [1:0] code;
    } base_code_t;

    function automatic base_code_t encode_base(logic [CHAR_W-1:0] c);
        base_code_t r;
        r.bad  = 1'b0;
        r.code = 2'd0;
        case (c)
            "A", "a": r.code = 2'd0;
            "C", "c": r.code = 2'd1;
            "G", "g": r.code = 2'd2;
            "T", "t": r.code = 2'd3;
            default:  r.bad  = 1'b1;
        endcase
        return r;
    endfunction

    // leading zeros of one chunk, LZ_CHUNK when all zero
    function automatic logic [LZ_W-1:0] chunk_lz(logic [LZ_CHUNK-1:0] v);
        logic [LZ_W-1:0] n;
        logic            found;
        n     = LZ_W'(LZ_CHUNK);
        found = 1'b0;
        for (int i = LZ_CHUNK - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = LZ_W'(LZ_CHUNK - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kmhll_in_if.sv =====
`default_nettype none

interface kmhll_in_if import kmhll_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [CHAR_W-1:0]   base_char;
    logic                first_base;
    logic [REG_IDX_W-1:0] read_index;

    modport source (output valid, kind, base_char, first_base, read_index, input ready);
    modport sink   (input valid, kind, base_char, first_base, read_index, output ready);
    modport monitor (input valid, ready, kind, base_char, first_base, read_index);
endinterface

`default_nettype wire

// ===== hw/rtl/kmhll_out_if.sv =====
`default_nettype none

interface kmhll_out_if import kmhll_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kmer_added;
    logic [REG_IDX_W-1:0] reg_index;
    logic [RANK_W-1:0]    rank;
    logic [RANK_W-1:0]    reg_value;

    modport source (output valid, kmer_added, reg_index, rank, reg_value, input ready);
    modport sink   (input valid, kmer_added, reg_index, rank, reg_value, output ready);
    modport monitor (input valid, ready, kmer_added, reg_index, rank, reg_value);
endinterface

`default_nettype wire

// ===== hw/rtl/kmer_hyperloglog_insert_top.sv =====
// Channel   Dir  Word contents                                  Handshake
// item      in   kind, base_char, first_base, read_index        valid/ready
// result    out  kmer_added, reg_index, rank, reg_value         valid/ready
//
// One word in flight at a time. A character with an insertion runs the
// seed mix, two fmix multiplies of three 32x32 partial products each on
// the one shared multiplier, rank search and sketch read-modify-write. A
// character without insertion goes straight to ST_DONE, a register read
// via ST_READ. After reset a clearing pass zeroes all 4096 sketch entries
// (item.ready low). A stalled result sits in the output register while
// the next word is taken; the block only waits when a new one is ready too.
`default_nettype none

module kmer_hyperloglog_insert_top import kmhll_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    kmhll_in_if.sink      item,
    kmhll_out_if.source   result
);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_READ   = 10'b0000000100,
        ST_MIX    = 10'b0000001000,
        ST_MUL_LO = 10'b0000010000,
        ST_MUL_X1 = 10'b0000100000,
        ST_MUL_X2 = 10'b0001000000,
        ST_LZC    = 10'b0010000000,
        ST_MERGE  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    // which xor-shift of the finalizer is next
    localparam logic [1:0] MIX_AFTER_SEED = 2'd0;
    localparam logic [1:0] MIX_AFTER_C0   = 2'd1;
    localparam logic [1:0] MIX_AFTER_C1   = 2'd2;

    state_t state_reg, state_next;

    // rolling k-mer window
    logic [WIN_W-1:0]       fwd_reg, rev_reg;
    logic [KMER_LENGTH-1:0] mask_reg;
    logic [HELD_W-1:0]      held_reg;

    // hash datapath
    logic [HASH_W-1:0]      x_reg;
    logic [HASH_W-1:0]      prod_reg;
    logic [HALF_W-1:0]      cross_reg;
    logic [1:0]             pass_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [LZ_W-1:0]        lz_reg [LZ_CHUNKS];
    logic [LZ_CHUNKS-1:0]   nz_reg;

    // sketch memory
    logic [RANK_W-1:0]      sketch_mem [1 << PRECISION];
    logic [RANK_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic [RANK_W-1:0]      mem_wdata;

    // staged and output result word
    logic                   res_added_reg;
    logic [REG_IDX_W-1:0]   res_idx_reg;
    logic [RANK_W-1:0]      res_rank_reg, res_val_reg;
    logic                   out_valid_reg;
    logic                   out_added_reg;
    logic [REG_IDX_W-1:0]   out_idx_reg;
    logic [RANK_W-1:0]      out_rank_reg, out_val_reg;

    logic accept, out_free;

    assign item.ready        = (state_reg == ST_IDLE);
    assign accept            = item.valid && item.ready;
    assign out_free          = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.kmer_added = out_added_reg;
    assign result.reg_index  = out_idx_reg;
    assign result.rank       = out_rank_reg;
    assign result.reg_value  = out_val_reg;

    // window as seen by this character (first_base restarts it)
    logic [WIN_W-1:0]       win_fwd, win_rev, canon;
    logic [KMER_LENGTH-1:0] win_mask;
    logic [HELD_W-1:0]      win_held;
    logic                   do_insert;
    base_code_t             enc;
    logic [1:0]             rcode;

    always_comb
    begin
        win_fwd   = item.first_base ? '0 : fwd_reg;
        win_rev   = item.first_base ? '0 : rev_reg;
        win_mask  = item.first_base ? '0 : mask_reg;
        win_held  = item.first_base ? '0 : held_reg;
        do_insert = (win_held >= HELD_W'(KMER_LENGTH)) && (win_mask == '0);
        canon     = (win_fwd <= win_rev) ? win_fwd : win_rev;
        enc       = encode_base(item.base_char);
        rcode     = enc.bad ? 2'd0 : (2'd3 - enc.code);
    end

    // shared 32x32 multiplier, low 64 bits of x * k built from three partial products
    logic [HASH_W-1:0] mul_k;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [HASH_W-1:0] mul_p;

    assign mul_k = (pass_reg == MIX_AFTER_SEED) ? FMIX_C0 : FMIX_C1;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_LO:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_k[HALF_W-1:0];
            end
            ST_MUL_X1:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_k[HASH_W-1:HALF_W];
            end
            ST_MUL_X2:
            begin
                mul_a = x_reg[HASH_W-1:HALF_W];
                mul_b = mul_k[HALF_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = HASH_W'(mul_a) * HASH_W'(mul_b);

    // rank tail: bits below the index, guard one appended
    logic [HASH_W-1:0] tail;
    assign tail = {x_reg[HASH_W-2:0], 1'b1} << (PRECISION - 1);

    logic [RSUM_W-1:0] rank_sum;
    logic [RANK_W-1:0] rank;
    logic              found;
    logic              rank_wins;

    always_comb
    begin
        rank_sum = '0;
        found    = 1'b0;
        for (int c = 0; c < LZ_CHUNKS; c++) begin
            if (!found && nz_reg[c]) begin
                rank_sum = RSUM_W'(c * LZ_CHUNK + int'(lz_reg[c]) + 1);
                found    = 1'b1;
            end
        end
        rank      = RANK_W'(rank_sum);
        rank_wins = rank > rd_data_reg;
    end

    // memory port control
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_MERGE) && rank_wins);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : rank;
        mem_re    = (accept && item.kind == KIND_READ) || (state_reg == ST_LZC);
        mem_raddr = (state_reg == ST_LZC) ? x_reg[HASH_W-1 -: IDX_W]
                                          : IDX_W'(item.read_index);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sketch_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= sketch_mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (&clr_reg) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept) begin
                    if (item.kind == KIND_READ)
                        state_next = ST_READ;
                    else if (do_insert)
                        state_next = ST_MIX;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_MIX:    state_next = (pass_reg == MIX_AFTER_C1) ? ST_LZC : ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_X1;
            ST_MUL_X1: state_next = ST_MUL_X2;
            ST_MUL_X2: state_next = ST_MIX;
            ST_LZC:    state_next = ST_MERGE;
            ST_MERGE:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            fwd_reg       <= '0;
            rev_reg       <= '0;
            mask_reg      <= '0;
            held_reg      <= '0;
            pass_reg      <= MIX_AFTER_SEED;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (accept && item.kind == KIND_CHAR) begin
                fwd_reg  <= {win_fwd[WIN_W-3:0], enc.code & {2{~enc.bad}}};
                rev_reg  <= {rcode, win_rev[WIN_W-1:2]};
                mask_reg <= {win_mask[KMER_LENGTH-2:0], enc.bad};
                if (win_held < HELD_W'(KMER_LENGTH))
                    held_reg <= win_held + 1'b1;
                else
                    held_reg <= win_held;
            end
            if (accept)
                pass_reg <= MIX_AFTER_SEED;
            else if (state_reg == ST_MUL_X2)
                pass_reg <= pass_reg + 1'b1;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg         <= canon ^ HASH_SEED;
                res_added_reg <= 1'b0;
                res_idx_reg   <= '0;
                res_rank_reg  <= '0;
                res_val_reg   <= '0;
                idx_reg       <= IDX_W'(item.read_index);
            end
            ST_READ:
            begin
                res_idx_reg <= REG_IDX_W'(idx_reg);
                res_val_reg <= rd_data_reg;
            end
            ST_MIX:    x_reg     <= x_reg ^ (x_reg >> MIX_SHIFT);
            ST_MUL_LO: prod_reg  <= mul_p;
            ST_MUL_X1: cross_reg <= mul_p[HALF_W-1:0];
            ST_MUL_X2:
            begin
                x_reg <= {prod_reg[HASH_W-1:HALF_W] + cross_reg + mul_p[HALF_W-1:0],
                          prod_reg[HALF_W-1:0]};
            end
            ST_LZC:
            begin
                idx_reg <= x_reg[HASH_W-1 -: IDX_W];
                for (int c = 0; c < LZ_CHUNKS; c++) begin
                    nz_reg[c] <= |tail[HASH_W-1-c*LZ_CHUNK -: LZ_CHUNK];
                    lz_reg[c] <= chunk_lz(tail[HASH_W-1-c*LZ_CHUNK -: LZ_CHUNK]);
                end
            end
            ST_MERGE:
            begin
                res_added_reg <= 1'b1;
                res_idx_reg   <= REG_IDX_W'(idx_reg);
                res_rank_reg  <= rank;
                res_val_reg   <= rank_wins ? rank : rd_data_reg;
            end
            ST_DONE:
            begin
                if (out_free) begin
                    out_added_reg <= res_added_reg;
                    out_idx_reg   <= res_idx_reg;
                    out_rank_reg  <= res_rank_reg;
                    out_val_reg   <= res_val_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kmhll_checker.sv =====
`default_nettype none

module kmhll_checker import kmhll_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic                 result_kmer_added,
    input logic [REG_IDX_W-1:0] result_reg_index,
    input logic [RANK_W-1:0]    result_rank,
    input logic [RANK_W-1:0]    result_reg_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_kmer_added)
            && $stable(result_reg_index) && $stable(result_rank)
            && $stable(result_reg_value))
        else $error("result word changed while stalled");

    // one word in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input accepted while a word is in flight");

    // insertion: rank in range, register never below it
    a_rank_merge: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kmer_added |-> result_rank != '0
            && result_rank <= RANK_W'(MAX_RANK) && result_reg_value >= result_rank)
        else $error("bad rank or merged value");

    a_no_rank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_kmer_added |-> result_rank == '0)
        else $error("rank without insertion");

endmodule

bind kmer_hyperloglog_insert_top kmhll_checker u_kmhll_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_kmer_added (result.kmer_added),
    .result_reg_index  (result.reg_index),
    .result_rank       (result.rank),
    .result_reg_value  (result.reg_value)
);

`default_nettype wire
